/* rtl/mwem_pkg.sv */
package mwem_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FRAME = 3'd1,
    PH_WDATA = 3'd2,
    PH_POLL  = 3'd3,
    PH_RDATA = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic REG_FRAME_BITS   = 1'b0;
  localparam logic REG_POLL_TIMEOUT = 1'b1;

  localparam logic [4:0]  FRAME_BITS_RST   = 5'd9;
  localparam logic [15:0] POLL_TIMEOUT_RST = 16'd10;
  localparam logic [4:0]  WORD_BITS        = 5'd16;
  localparam logic [15:0] FRAME_MASK       = 16'h1FFF;

  // one queued request: tick fields with the frame already built
  typedef struct packed {
    logic        start;
    logic [1:0]  kind;
    logic [15:0] frame;
    logic [15:0] wdata;
    logic        miso;
  } req_t;

  typedef struct packed {
    logic [4:0]  frame_bits;
    logic [15:0] poll_limit;
  } cfg_t;

endpackage

/* rtl/mwem_front.sv */
module mwem_front (
  input  logic             clk,
  input  logic             rst_n,
  input  mwem_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_op,
  input  logic [1:0]       in_kind,
  input  logic [7:0]       in_opcode,
  input  logic [7:0]       in_address,
  input  logic [15:0]      in_write_data,
  input  logic             in_miso,
  output logic             q_valid,
  output mwem_pkg::req_t   q_data,
  input  logic             q_pop
);

  localparam logic [4:0] WORD_SHIFT = mwem_pkg::WORD_BITS;

  mwem_pkg::req_t q_mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  logic [3:0]     shamt;
  logic [15:0]    addr_sh;
  mwem_pkg::req_t req;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = q_mem_r[rd_ptr_r];

  assign shamt   = 4'(WORD_SHIFT - cfg.frame_bits);
  assign addr_sh = {8'd0, in_address} << shamt;

  always_comb begin
    req.start = in_op;
    req.kind  = in_kind;
    req.frame = (addr_sh & mwem_pkg::FRAME_MASK) | {in_opcode, 8'd0};
    req.wdata = in_write_data;
    req.miso  = in_miso;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = 2'(count_r + {1'b0, push} - {1'b0, q_pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= req;
    end
  end

endmodule

/* rtl/mwem_back.sv */
module mwem_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mwem_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  mwem_pkg::req_t   q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_chip_select,
  output logic             out_serial_clock,
  output logic             out_mosi,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [15:0]      out_read_data,
  output logic             out_timed_out
);

  mwem_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  bit_cnt_r, bit_cnt_nxt;
  logic        half_r, half_nxt;
  logic [15:0] frame_r, frame_nxt;
  logic [15:0] data_r, data_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] poll_r, poll_nxt;
  logic        tmo_r, tmo_nxt;
  logic        cs_r, cs_nxt;
  logic        sck_r, sck_nxt;
  logic        mosi_r, mosi_nxt;
  logic [15:0] rword_r, rword_nxt;
  logic        done_r, done_nxt;
  logic        valid_r;

  logic        advance;
  logic [4:0]  bc_inc;
  logic [15:0] poll_inc;
  logic        frame_end, word_end, poll_expire;
  logic [15:0] rd_shift;

  assign advance  = !valid_r || !out_stall;
  assign q_pop    = q_valid && advance;

  assign bc_inc      = bit_cnt_r + 5'd1;
  assign poll_inc    = poll_r + 16'd1;
  assign frame_end   = (bc_inc >= cfg.frame_bits);
  assign word_end    = (bc_inc >= mwem_pkg::WORD_BITS);
  assign poll_expire = (poll_inc >= cfg.poll_limit);
  assign rd_shift    = {data_r[14:0], q_data.miso};

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      mwem_pkg::PH_IDLE: begin
        if (q_data.start) phase_nxt = mwem_pkg::PH_FRAME;
      end
      mwem_pkg::PH_FRAME: begin
        if (half_r && frame_end) begin
          if (kind_r == mwem_pkg::KIND_WRITE) phase_nxt = mwem_pkg::PH_WDATA;
          else if (kind_r == mwem_pkg::KIND_READ) phase_nxt = mwem_pkg::PH_RDATA;
          else phase_nxt = mwem_pkg::PH_IDLE;
        end
      end
      mwem_pkg::PH_WDATA: begin
        if (half_r && word_end) phase_nxt = mwem_pkg::PH_POLL;
      end
      mwem_pkg::PH_POLL: begin
        if (q_data.miso || poll_expire) phase_nxt = mwem_pkg::PH_IDLE;
      end
      mwem_pkg::PH_RDATA: begin
        if (half_r && word_end) phase_nxt = mwem_pkg::PH_IDLE;
      end
      default: phase_nxt = mwem_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    bit_cnt_nxt = bit_cnt_r;
    half_nxt    = half_r;
    frame_nxt   = frame_r;
    data_nxt    = data_r;
    kind_nxt    = kind_r;
    poll_nxt    = poll_r;
    tmo_nxt     = tmo_r;
    cs_nxt      = cs_r;
    sck_nxt     = sck_r;
    mosi_nxt    = mosi_r;
    rword_nxt   = rword_r;
    done_nxt    = 1'b0;
    unique case (phase_r)
      mwem_pkg::PH_IDLE: begin
        if (q_data.start) begin
          frame_nxt   = q_data.frame;
          data_nxt    = q_data.wdata;
          kind_nxt    = q_data.kind;
          bit_cnt_nxt = 5'd0;
          half_nxt    = 1'b0;
          poll_nxt    = 16'd0;
          cs_nxt      = 1'b1;
          sck_nxt     = 1'b0;
        end
      end
      mwem_pkg::PH_FRAME: begin
        if (!half_r) begin
          mosi_nxt = frame_r[15];
          sck_nxt  = 1'b1;
          half_nxt = 1'b1;
        end else begin
          sck_nxt     = 1'b0;
          half_nxt    = 1'b0;
          frame_nxt   = {frame_r[14:0], 1'b0};
          bit_cnt_nxt = bc_inc;
          if (frame_end) begin
            bit_cnt_nxt = 5'd0;
            if (kind_r == mwem_pkg::KIND_READ) begin
              data_nxt = 16'd0;
            end else if (kind_r != mwem_pkg::KIND_WRITE) begin
              cs_nxt   = 1'b0;
              done_nxt = 1'b1;
            end
          end
        end
      end
      mwem_pkg::PH_WDATA: begin
        if (!half_r) begin
          mosi_nxt = data_r[15];
          sck_nxt  = 1'b1;
          half_nxt = 1'b1;
        end else begin
          sck_nxt     = 1'b0;
          half_nxt    = 1'b0;
          data_nxt    = {data_r[14:0], 1'b0};
          bit_cnt_nxt = bc_inc;
          if (word_end) begin
            bit_cnt_nxt = 5'd0;
            cs_nxt      = 1'b0;
            poll_nxt    = 16'd0;
          end
        end
      end
      mwem_pkg::PH_POLL: begin
        cs_nxt = 1'b1;
        if (q_data.miso) begin
          cs_nxt      = 1'b0;
          sck_nxt     = 1'b0;
          bit_cnt_nxt = 5'd0;
          half_nxt    = 1'b0;
          done_nxt    = 1'b1;
        end else begin
          poll_nxt = poll_inc;
          if (poll_expire) begin
            tmo_nxt     = 1'b1;
            cs_nxt      = 1'b0;
            sck_nxt     = 1'b0;
            bit_cnt_nxt = 5'd0;
            half_nxt    = 1'b0;
            done_nxt    = 1'b1;
          end
        end
      end
      mwem_pkg::PH_RDATA: begin
        if (!half_r) begin
          sck_nxt  = 1'b1;
          half_nxt = 1'b1;
        end else begin
          sck_nxt     = 1'b0;
          half_nxt    = 1'b0;
          data_nxt    = rd_shift;
          bit_cnt_nxt = bc_inc;
          if (word_end) begin
            rword_nxt   = rd_shift;
            cs_nxt      = 1'b0;
            bit_cnt_nxt = 5'd0;
            done_nxt    = 1'b1;
          end
        end
      end
      default: begin
        cs_nxt      = 1'b0;
        sck_nxt     = 1'b0;
        bit_cnt_nxt = 5'd0;
        half_nxt    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= mwem_pkg::PH_IDLE;
      bit_cnt_r <= 5'd0;
      half_r    <= 1'b0;
      frame_r   <= 16'd0;
      data_r    <= 16'd0;
      kind_r    <= 2'd0;
      poll_r    <= 16'd0;
      tmo_r     <= 1'b0;
      cs_r      <= 1'b0;
      sck_r     <= 1'b0;
      mosi_r    <= 1'b0;
      rword_r   <= 16'd0;
      done_r    <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r   <= phase_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        half_r    <= half_nxt;
        frame_r   <= frame_nxt;
        data_r    <= data_nxt;
        kind_r    <= kind_nxt;
        poll_r    <= poll_nxt;
        tmo_r     <= tmo_nxt;
        cs_r      <= cs_nxt;
        sck_r     <= sck_nxt;
        mosi_r    <= mosi_nxt;
        rword_r   <= rword_nxt;
        done_r    <= done_nxt;
      end
      if (advance) begin
        valid_r <= q_valid;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_chip_select  = cs_r;
  assign out_serial_clock = sck_r;
  assign out_mosi         = mosi_r;
  assign out_busy_res     = (phase_r != mwem_pkg::PH_IDLE);
  assign out_done_res     = done_r;
  assign out_read_data    = rword_r;
  assign out_timed_out    = tmo_r;

endmodule

/* rtl/microwire_eeprom_master.sv */
// Microwire serial EEPROM master, one half-bit tick per request.
// Input channel (in_*): every request is one tick of the serial clock.
// in_op=1 while idle starts a transaction of kind in_kind (command, write
// with ready poll, read); starts while busy are ignored and just tick.
// Result channel (out_*): exactly one result per request, giving the pin
// levels, busy, done, the last read word and the sticky timeout flag.
// A request's result is registered twice: it is held in the request queue,
// then in the tick engine's state registers. Throughput: one request per
// cycle while the receiver does not stall, set by the single-step tick
// engine. A two-entry queue separates the two sides.
// When the receiver stalls, the engine holds its result and state; the
// queue keeps taking requests until both entries fill, then in_stall rises.
// Reset (rst_n low, synchronous) empties the queue, idles the engine,
// drops all pins and flags, and loads frame_bits=9, poll_timeout=10.
// APB registers: 0x0 frame_bits (5 bits), 0x4 poll_timeout (16 bits);
// write only while idle.
module microwire_eeprom_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_address,
  input  logic [15:0] in_write_data,
  input  logic        in_miso,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_chip_select,
  output logic        out_serial_clock,
  output logic        out_mosi,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [15:0] out_read_data,
  output logic        out_timed_out
);

  logic [4:0]     frame_bits_r;
  logic [15:0]    poll_timeout_r;
  logic           cfg_wr;
  mwem_pkg::cfg_t cfg;
  logic           q_valid;
  logic           q_pop;
  mwem_pkg::req_t q_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bits_r   <= mwem_pkg::FRAME_BITS_RST;
      poll_timeout_r <= mwem_pkg::POLL_TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == mwem_pkg::REG_FRAME_BITS) frame_bits_r <= pwdata[4:0];
      else poll_timeout_r <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == mwem_pkg::REG_POLL_TIMEOUT) prdata = {16'd0, poll_timeout_r};
    else prdata = {27'd0, frame_bits_r};
  end

  always_comb begin
    if (frame_bits_r == 5'd0) cfg.frame_bits = 5'd1;
    else if (frame_bits_r > mwem_pkg::WORD_BITS) cfg.frame_bits = mwem_pkg::WORD_BITS;
    else cfg.frame_bits = frame_bits_r;
    cfg.poll_limit = (poll_timeout_r == 16'd0) ? 16'd1 : poll_timeout_r;
  end

  mwem_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_kind       (in_kind),
    .in_opcode     (in_opcode),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_miso       (in_miso),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop)
  );

  mwem_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chip_select  (out_chip_select),
    .out_serial_clock (out_serial_clock),
    .out_mosi         (out_mosi),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data),
    .out_timed_out    (out_timed_out)
  );

endmodule

/* rtl/mwem_checker.sv */
module mwem_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_chip_select,
  input logic        out_serial_clock,
  input logic        out_busy_res,
  input logic        out_done_res,
  input logic [15:0] out_read_data,
  input logic        out_timed_out
);

  // a completing tick has already left the busy phase and dropped the pins
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && !out_chip_select && !out_serial_clock)
    else $error("done result still shows busy or active pins");

  a_idle_sck_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> !out_serial_clock)
    else $error("serial clock high while idle");

  a_timeout_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_timed_out) |-> out_timed_out)
    else $error("timeout flag cleared without reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) && $stable(out_done_res))
    else $error("stalled result changed");

endmodule

bind microwire_eeprom_master mwem_checker u_mwem_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_chip_select  (out_chip_select),
  .out_serial_clock (out_serial_clock),
  .out_busy_res     (out_busy_res),
  .out_done_res     (out_done_res),
  .out_read_data    (out_read_data),
  .out_timed_out    (out_timed_out)
);

/* verif/testbench.sv */
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int HOLD_AT        = 30;
  localparam int HOLD_CYCLES    = 120;
  localparam int CALM_FROM      = 300;
  localparam int CALM_TO        = 500;
  localparam int PHASE_ITEMS    = 40;
  localparam int NEVER_READY    = 70000;

  localparam logic       OP_TICK    = 1'b0;
  localparam logic       OP_START   = 1'b1;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic        op;
    logic [1:0]  kind;
    logic [7:0]  opcode;
    logic [7:0]  address;
    logic [15:0] write_data;
    logic        miso;
  } tick_t;

  typedef struct packed {
    logic        chip_select;
    logic        serial_clock;
    logic        mosi;
    logic        busy;
    logic        done;
    logic [15:0] read_data;
    logic        timed_out;
  } pins_t;

  typedef struct packed {
    tick_t      tick;
    logic [7:0] reps;
    logic       typed;
    pins_t      pins;
  } stim_row_t;

  localparam pins_t PINS_QUIET = '0;
  localparam pins_t PINS_OPEN  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_stall, in_op, in_miso;
  logic [1:0]  in_kind;
  logic [7:0]  in_opcode, in_address;
  logic [15:0] in_write_data;
  logic        out_valid, out_stall;
  logic        out_chip_select, out_serial_clock, out_mosi;
  logic        out_busy_res, out_done_res, out_timed_out;
  logic [15:0] out_read_data;

  always #5 clk = ~clk;

  microwire_eeprom_master i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_kind          (in_kind),
    .in_opcode        (in_opcode),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .in_miso          (in_miso),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chip_select  (out_chip_select),
    .out_serial_clock (out_serial_clock),
    .out_mosi         (out_mosi),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data),
    .out_timed_out    (out_timed_out)
  );

  // master state mirror
  mwem_pkg::phase_t ph;
  logic [4:0]  bits_done;
  logic        sck_half;
  logic [15:0] frame_sr;
  logic [15:0] data_sr;
  logic [1:0]  kind_latched;
  logic [15:0] poll_ticks;
  logic        timeout_seen;
  logic        cs_lvl, sck_lvl, mosi_lvl;
  logic [15:0] last_read_word;
  logic [4:0]  frame_bits_reg;
  logic [15:0] poll_limit_reg;

  pins_t pin_levels_due[$];
  int    mismatch_count = 0;
  int    sent_count = 0;
  int    seen_count = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;
  int    idle_cycles = 0;

  stim_row_t dir_rows [15] = '{
    '{'{OP_TICK, mwem_pkg::KIND_CMD, 8'h00, 8'h00, 16'h0000, 1'b0}, 8'd1, 1'b1, PINS_QUIET},
    '{'{OP_TICK, KIND_SPARE, 8'hFF, 8'hFF, 16'hFFFF, 1'b1}, 8'd1, 1'b1, PINS_QUIET},
    '{'{OP_START, mwem_pkg::KIND_CMD, 8'hFF, 8'hFF, 16'h0000, 1'b0}, 8'd1, 1'b1, PINS_OPEN},
    '{'{OP_START, mwem_pkg::KIND_READ, 8'h00, 8'h00, 16'hFFFF, 1'b1}, 8'd1, 1'b0, PINS_QUIET},
    '{'{OP_TICK, mwem_pkg::KIND_CMD, 8'h00, 8'h00, 16'h0000, 1'b1}, 8'd17, 1'b0, PINS_QUIET},
    '{'{OP_START, mwem_pkg::KIND_WRITE, 8'h00, 8'h00, 16'hFFFF, 1'b0}, 8'd1, 1'b0, PINS_QUIET},
    '{'{OP_TICK, mwem_pkg::KIND_CMD, 8'h00, 8'h00, 16'h0000, 1'b0}, 8'd60, 1'b0, PINS_QUIET},
    '{'{OP_TICK, mwem_pkg::KIND_CMD, 8'h00, 8'h00, 16'h0000, 1'b0}, 8'd1, 1'b0, PINS_QUIET},
    '{'{OP_START, mwem_pkg::KIND_WRITE, 8'hA5, 8'h5A, 16'h0000, 1'b0}, 8'd1, 1'b0, PINS_QUIET},
    '{'{OP_TICK, mwem_pkg::KIND_CMD, 8'h00, 8'h00, 16'h0000, 1'b0}, 8'd50, 1'b0, PINS_QUIET},
    '{'{OP_TICK, mwem_pkg::KIND_CMD, 8'h00, 8'h00, 16'h0000, 1'b1}, 8'd1, 1'b0, PINS_QUIET},
    '{'{OP_START, mwem_pkg::KIND_READ, 8'h00, 8'hFF, 16'h0000, 1'b0}, 8'd1, 1'b0, PINS_QUIET},
    '{'{OP_TICK, mwem_pkg::KIND_CMD, 8'h00, 8'h00, 16'h0000, 1'b1}, 8'd50, 1'b0, PINS_QUIET},
    '{'{OP_START, KIND_SPARE, 8'h80, 8'h01, 16'h0000, 1'b0}, 8'd1, 1'b0, PINS_QUIET},
    '{'{OP_TICK, mwem_pkg::KIND_CMD, 8'h00, 8'h00, 16'h0000, 1'b0}, 8'd18, 1'b0, PINS_QUIET}
  };

  function automatic void master_reset();
    ph             = mwem_pkg::PH_IDLE;
    bits_done      = '0;
    sck_half       = 1'b0;
    frame_sr       = '0;
    data_sr        = '0;
    kind_latched   = mwem_pkg::KIND_CMD;
    poll_ticks     = '0;
    timeout_seen   = 1'b0;
    cs_lvl         = 1'b0;
    sck_lvl        = 1'b0;
    mosi_lvl       = 1'b0;
    last_read_word = '0;
    frame_bits_reg = mwem_pkg::FRAME_BITS_RST;
    poll_limit_reg = mwem_pkg::POLL_TIMEOUT_RST;
  endfunction

  // advances the mirror by one half-bit tick and returns the pin levels after it
  function automatic pins_t master_tick(tick_t t);
    logic [4:0]  fb;
    logic [31:0] shifted;
    logic [15:0] lim;
    logic        fin;
    fb  = (frame_bits_reg == 0) ? 5'd1 :
          (frame_bits_reg > mwem_pkg::WORD_BITS) ? mwem_pkg::WORD_BITS : frame_bits_reg;
    fin = 1'b0;
    unique case (ph)
      mwem_pkg::PH_IDLE: begin
        if (t.op) begin
          shifted      = 32'(t.address) << (16 - fb);
          frame_sr     = (shifted[15:0] & mwem_pkg::FRAME_MASK) | {t.opcode, 8'h00};
          data_sr      = t.write_data;
          kind_latched = t.kind;
          bits_done    = '0;
          sck_half     = 1'b0;
          poll_ticks   = '0;
          cs_lvl       = 1'b1;
          sck_lvl      = 1'b0;
          ph           = mwem_pkg::PH_FRAME;
        end
      end
      mwem_pkg::PH_FRAME: begin
        if (!sck_half) begin
          mosi_lvl = frame_sr[15];
          sck_lvl  = 1'b1;
          sck_half = 1'b1;
        end else begin
          sck_lvl   = 1'b0;
          sck_half  = 1'b0;
          frame_sr  = frame_sr << 1;
          bits_done = bits_done + 5'd1;
          if (bits_done >= fb) begin
            bits_done = '0;
            if (kind_latched == mwem_pkg::KIND_WRITE) begin
              ph = mwem_pkg::PH_WDATA;
            end else if (kind_latched == mwem_pkg::KIND_READ) begin
              data_sr = '0;
              ph      = mwem_pkg::PH_RDATA;
            end else begin
              fin = 1'b1;
            end
          end
        end
      end
      mwem_pkg::PH_WDATA: begin
        if (!sck_half) begin
          mosi_lvl = data_sr[15];
          sck_lvl  = 1'b1;
          sck_half = 1'b1;
        end else begin
          sck_lvl   = 1'b0;
          sck_half  = 1'b0;
          data_sr   = data_sr << 1;
          bits_done = bits_done + 5'd1;
          if (bits_done >= mwem_pkg::WORD_BITS) begin
            bits_done  = '0;
            cs_lvl     = 1'b0;
            poll_ticks = '0;
            ph         = mwem_pkg::PH_POLL;
          end
        end
      end
      mwem_pkg::PH_POLL: begin
        cs_lvl = 1'b1;
        if (t.miso) begin
          fin = 1'b1;
        end else begin
          lim        = (poll_limit_reg == 0) ? 16'd1 : poll_limit_reg;
          poll_ticks = poll_ticks + 16'd1;
          if (poll_ticks >= lim) begin
            timeout_seen = 1'b1;
            fin          = 1'b1;
          end
        end
      end
      mwem_pkg::PH_RDATA: begin
        if (!sck_half) begin
          sck_lvl  = 1'b1;
          sck_half = 1'b1;
        end else begin
          sck_lvl   = 1'b0;
          sck_half  = 1'b0;
          data_sr   = {data_sr[14:0], t.miso};
          bits_done = bits_done + 5'd1;
          if (bits_done >= mwem_pkg::WORD_BITS) begin
            last_read_word = data_sr;
            fin            = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (fin) begin
      cs_lvl    = 1'b0;
      sck_lvl   = 1'b0;
      ph        = mwem_pkg::PH_IDLE;
      bits_done = '0;
      sck_half  = 1'b0;
    end
    return '{cs_lvl, sck_lvl, mosi_lvl, ph != mwem_pkg::PH_IDLE, fin, last_read_word,
             timeout_seen};
  endfunction

  function automatic string fmt_pins(pins_t p);
    return $sformatf("cs=%b sck=%b mosi=%b busy=%b done=%b rd=%h to=%b",
                     p.chip_select, p.serial_clock, p.mosi, p.busy, p.done,
                     p.read_data, p.timed_out);
  endfunction

  function automatic void flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.op         = 1'($urandom_range(0, 1));
    t.kind       = 2'($urandom_range(0, 3));
    t.opcode     = 8'($urandom_range(0, 255));
    t.address    = 8'($urandom_range(0, 255));
    t.write_data = 16'($urandom_range(0, 65535));
    t.miso       = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic bit sender_calm();
    return sent_count >= CALM_FROM && sent_count < CALM_TO;
  endfunction

  task automatic send_tick(tick_t t, logic typed, pins_t typed_pins);
    pins_t p;
    p = master_tick(t);
    pin_levels_due.push_back(typed ? typed_pins : p);
    while (!sender_calm() && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= t.op;
    in_kind       <= t.kind;
    in_opcode     <= t.opcode;
    in_address    <= t.address;
    in_write_data <= t.write_data;
    in_miso       <= t.miso;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pin_levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(logic regsel, logic [31:0] want);
    logic [31:0] rd;
    apb_access(1'b0, {regsel, 2'b00}, 32'h0, rd);
    if (rd !== want)
      flag_error($sformatf("register %0d readback: expected %h, got %h", regsel, want, rd));
  endtask

  task automatic write_config(logic [4:0] fb, logic [15:0] lim);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, {mwem_pkg::REG_FRAME_BITS, 2'b00}, {27'($urandom), fb}, rd);
    apb_access(1'b1, {mwem_pkg::REG_POLL_TIMEOUT, 2'b00}, {16'($urandom), lim}, rd);
    frame_bits_reg = fb;
    poll_limit_reg = lim;
    check_register(mwem_pkg::REG_FRAME_BITS, 32'(fb));
    check_register(mwem_pkg::REG_POLL_TIMEOUT, 32'(lim));
  endtask

  task automatic run_transaction(logic [1:0] kind, bit force_timeout);
    tick_t t;
    int    ready_at;
    if (force_timeout || (poll_limit_reg <= 64 && $urandom_range(0, 99) < 25))
      ready_at = NEVER_READY;
    else
      ready_at = $urandom_range(0, 12);
    repeat ($urandom_range(0, 2)) begin
      t    = random_tick();
      t.op = OP_TICK;
      send_tick(t, 1'b0, PINS_QUIET);
    end
    t      = random_tick();
    t.op   = OP_START;
    t.kind = kind;
    send_tick(t, 1'b0, PINS_QUIET);
    while (ph != mwem_pkg::PH_IDLE) begin
      t    = random_tick();
      t.op = ($urandom_range(0, 99) < 8) ? OP_START : OP_TICK;
      if (ph == mwem_pkg::PH_POLL) t.miso = (int'(poll_ticks) >= ready_at);
      send_tick(t, 1'b0, PINS_QUIET);
    end
  endtask

  task automatic run_phase(int budget);
    int first;
    first = sent_count;
    while (sent_count - first < budget) run_transaction(2'($urandom_range(0, 3)), 1'b0);
  endtask

  always @(posedge clk) begin : result_check
    pins_t got;
    pins_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_chip_select, out_serial_clock, out_mosi, out_busy_res, out_done_res,
              out_read_data, out_timed_out};
      if (pin_levels_due.size() == 0) begin
        flag_error($sformatf("result %0d with nothing pending: %s", seen_count, fmt_pins(got)));
      end else begin
        want = pin_levels_due.pop_front();
        if (got !== want)
          flag_error($sformatf("result %0d: expected %s, got %s",
                               seen_count, fmt_pins(want), fmt_pins(got)));
      end
      seen_count++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (seen_count == HOLD_AT && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !(seen_count >= CALM_FROM && seen_count < CALM_TO) &&
                   ($urandom_range(0, 99) < 38);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid      <= 1'b0;
    in_op         <= OP_TICK;
    in_kind       <= mwem_pkg::KIND_CMD;
    in_opcode     <= '0;
    in_address    <= '0;
    in_write_data <= '0;
    in_miso       <= 1'b0;
    out_stall     <= 1'b0;
    master_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    check_register(mwem_pkg::REG_FRAME_BITS, 32'(mwem_pkg::FRAME_BITS_RST));
    check_register(mwem_pkg::REG_POLL_TIMEOUT, 32'(mwem_pkg::POLL_TIMEOUT_RST));

    foreach (dir_rows[r])
      repeat (dir_rows[r].reps) send_tick(dir_rows[r].tick, dir_rows[r].typed, dir_rows[r].pins);

    write_config(5'd1, 16'd1);
    run_phase(PHASE_ITEMS);
    write_config(5'd16, 16'd0);
    run_phase(PHASE_ITEMS);
    write_config(5'd0, 16'd5);
    run_phase(PHASE_ITEMS);
    write_config(5'd31, 16'd3);
    run_phase(PHASE_ITEMS);
    write_config(5'($urandom_range(2, 15)), 16'($urandom_range(1, 20)));
    run_phase(PHASE_ITEMS);
    write_config(5'($urandom_range(17, 30)), 16'($urandom_range(1, 40)));
    run_phase(PHASE_ITEMS);
    // long busy poll, run out to the timeout once
    write_config(5'($urandom_range(1, 16)), 16'd48);
    run_transaction(mwem_pkg::KIND_WRITE, 1'b1);
    run_phase(PHASE_ITEMS / 2);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pin_levels_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mwem_pkg.sv
rtl/mwem_front.sv
rtl/mwem_back.sv
rtl/microwire_eeprom_master.sv
rtl/mwem_checker.sv
verif/testbench.sv
